// ===== hdl/padsr_pkg.sv =====
// Shared types, constants and helpers for the polyphonic ADSR envelope core.
// No dependencies; imported by every module of the block.
package padsr_pkg;

    localparam int LEVEL_W    = 24;
    localparam int CFG_W      = 12;
    localparam int NOTE_W     = 7;
    localparam int OP_W       = 2;
    localparam int VIDX_W     = 2;
    localparam int DIVISOR_W  = CFG_W + 1;
    localparam int VOICES_DEF = 4;

    localparam logic [LEVEL_W-1:0] ONE_Q23 = 24'h800000;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } t_phase;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_SUSTAIN = 2'd2,
        REG_RELEASE = 2'd3
    } t_reg;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        t_phase             phase;
        logic               active;
        logic               gate;
    } t_voice;

    typedef struct packed {
        logic                 start;
        logic [LEVEL_W-1:0]   dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } t_div_rsp;

    // sustain knob scaled to Q1.23 (value/4096 of full scale)
    function automatic logic [LEVEL_W-1:0] sus_q23(input logic [CFG_W-1:0] sus);
        sus_q23 = {1'b0, sus, 11'b0};
    endfunction

endpackage

// ===== hdl/polyphonic_adsr_envelope_core.sv =====
// Polyphonic ADSR envelope core: voice store, sequencer, APB registers, output register.
// Depends on padsr_pkg, padsr_div and padsr_voice.
//
// Usage:
//   Slave stream: tuser carries the op (tick, note on, note off), tdata[6:0] the note.
//   Note on and note off are applied in the transaction's own cycle; ready stays high.
//   A tick computes the attack, decay and release steps with the shared divider
//   (three divisions in turn, one quotient bit per cycle), then walks the
//   voices one per cycle through the envelope unit while the output register is
//   free, sending one transaction each. Ready is low during the whole tick.
//   Master stream: tuser is the voice index, tlast marks the last voice of a tick.
//   A result sits in an output register; when the receiver stalls, the walk holds
//   on the current voice until the register is taken, and the next item may be
//   accepted while the last result of a tick still waits.
//   APB: registers attack, decay, sustain, release at byte 0, 4, 8, 12; pready is
//   always high. Write them only while the block is idle.
//   Reset (synchronous, active low): all voices silent in attack at level 0, gates off,
//   notes 0, knobs 0 except sustain at 2048, no result pending.
module polyphonic_adsr_envelope_core
    import padsr_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // slave stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [7:0]          i_s_tdata,   // [6:0] note_number
    input  logic [OP_W-1:0]     i_s_tuser,   // [1:0] op
    // master stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [31:0]         o_m_tdata,   // [23:0] env_level, [25:24] env_phase,
                                             // [26] voice_active, [27] gate_on
    output logic [VIDX_W-1:0]   o_m_tuser,   // [1:0] voice_index
    output logic                o_m_tlast,   // last_voice
    // configuration
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [3:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output logic [31:0]         o_prdata,
    output logic                o_pready
);

    localparam int IDXW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int HCW  = $clog2(VOICES + 1);

    typedef enum logic [1:0] {S_IDLE, S_DSTART, S_DWAIT, S_VOICE} t_state;
    typedef enum logic [1:0] {SEL_ATTACK, SEL_DECAY, SEL_RELEASE} t_sel;

    // configuration registers
    logic [CFG_W-1:0] r_attack;
    logic [CFG_W-1:0] r_decay;
    logic [CFG_W-1:0] r_sustain;
    logic [CFG_W-1:0] r_release;
    t_reg             w_reg;

    assign w_reg    = t_reg'(i_paddr[3:2]);
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= '0;
            r_decay   <= '0;
            r_sustain <= CFG_W'(2048);
            r_release <= '0;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (w_reg)
                REG_ATTACK:  r_attack  <= i_pwdata[CFG_W-1:0];
                REG_DECAY:   r_decay   <= i_pwdata[CFG_W-1:0];
                REG_SUSTAIN: r_sustain <= i_pwdata[CFG_W-1:0];
                default:     r_release <= i_pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_ATTACK:  o_prdata = {{(32-CFG_W){1'b0}}, r_attack};
            REG_DECAY:   o_prdata = {{(32-CFG_W){1'b0}}, r_decay};
            REG_SUSTAIN: o_prdata = {{(32-CFG_W){1'b0}}, r_sustain};
            default:     o_prdata = {{(32-CFG_W){1'b0}}, r_release};
        endcase
    end

    // sequencer state and voice store
    t_state             r_state;
    t_sel               r_sel;
    logic [IDXW-1:0]    r_vidx;
    t_voice             r_voice [VOICES];
    logic [NOTE_W-1:0]  r_note  [VOICES];
    logic [LEVEL_W-1:0] r_step_a;
    logic [LEVEL_W-1:0] r_step_d;
    logic [LEVEL_W-1:0] r_step_r;
    logic               r_m_valid;
    logic [31:0]        r_m_data;
    logic [VIDX_W-1:0]  r_m_user;
    logic               r_m_last;

    t_div_req           w_req;
    t_div_rsp           w_rsp;
    t_voice             w_nxt;
    logic [VOICES-1:0]  w_gates;
    logic [HCW-1:0]     w_held;
    logic [IDXW-1:0]    w_slot;
    logic               w_accept;
    logic [NOTE_W-1:0]  w_note;
    logic [LEVEL_W-1:0] w_sus;
    logic [4:0]         w_vidx_ext;
    logic               w_last;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_note     = i_s_tdata[NOTE_W-1:0];
    assign w_sus      = sus_q23(r_sustain);
    assign w_vidx_ext = 5'(r_vidx);
    assign w_last     = (r_vidx == IDXW'(VOICES - 1));

    always_comb begin
        for (int v = 0; v < VOICES; v++) begin
            w_gates[v] = r_voice[v].gate;
        end
        w_held = HCW'($countones(w_gates));
        w_slot = w_held[IDXW-1:0];
    end

    always_comb begin
        w_req.start = (r_state == S_DSTART);
        unique case (r_sel)
            SEL_ATTACK: begin
                w_req.dividend = ONE_Q23;
                w_req.divisor  = {1'b0, r_attack} + DIVISOR_W'(1);
            end
            SEL_DECAY: begin
                w_req.dividend = ONE_Q23 - w_sus;
                w_req.divisor  = {1'b0, r_decay} + DIVISOR_W'(1);
            end
            default: begin
                w_req.dividend = w_sus;
                w_req.divisor  = {1'b0, r_release} + DIVISOR_W'(1);
            end
        endcase
    end

    padsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    padsr_voice u_voice (
        .i_cur     (r_voice[r_vidx]),
        .i_sustain (r_sustain),
        .i_step_a  (r_step_a),
        .i_step_d  (r_step_d),
        .i_step_r  (r_step_r),
        .o_nxt     (w_nxt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sel     <= SEL_ATTACK;
            r_vidx    <= '0;
            r_m_valid <= 1'b0;
            for (int v = 0; v < VOICES; v++) begin
                r_voice[v] <= '{level: '0, phase: PH_ATTACK, active: 1'b0, gate: 1'b0};
                r_note[v]  <= '0;
            end
        end else begin
            // during the walk the output register is reloaded whenever it is taken
            if (i_m_tready && r_state != S_VOICE) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (i_s_tuser)
                            OP_TICK: begin
                                r_sel   <= SEL_ATTACK;
                                r_state <= S_DSTART;
                            end
                            OP_NOTE_ON: begin
                                if (w_held < HCW'(VOICES)) begin
                                    r_voice[w_slot] <= '{level: '0, phase: PH_ATTACK,
                                                         active: 1'b1, gate: 1'b1};
                                    r_note[w_slot]  <= w_note;
                                end
                            end
                            OP_NOTE_OFF: begin
                                for (int v = 0; v < VOICES; v++) begin
                                    if (r_note[v] == w_note) begin
                                        r_voice[v].gate <= 1'b0;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_rsp.done) begin
                        unique case (r_sel)
                            SEL_ATTACK: begin
                                r_step_a <= w_rsp.quotient;
                                r_sel    <= SEL_DECAY;
                                r_state  <= S_DSTART;
                            end
                            SEL_DECAY: begin
                                r_step_d <= w_rsp.quotient;
                                r_sel    <= SEL_RELEASE;
                                r_state  <= S_DSTART;
                            end
                            default: begin
                                r_step_r <= w_rsp.quotient;
                                r_vidx   <= '0;
                                r_state  <= S_VOICE;
                            end
                        endcase
                    end
                end
                default: begin
                    // advance one voice whenever the output register is free
                    if (!r_m_valid || i_m_tready) begin
                        r_voice[r_vidx] <= w_nxt;
                        r_m_valid       <= 1'b1;
                        r_m_data        <= {4'b0, w_nxt.gate, w_nxt.active,
                                            w_nxt.phase, w_nxt.level};
                        r_m_user        <= w_vidx_ext[VIDX_W-1:0];
                        r_m_last        <= w_last;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_vidx <= r_vidx + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

endmodule

// ===== hdl/padsr_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the envelope sequencer.
// Depends on padsr_pkg (widths and request/response structs).
module padsr_div
    import padsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(LEVEL_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [LEVEL_W-1:0]   r_quo;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_dvs;

    logic [DIVISOR_W:0]   w_trial;
    logic [DIVISOR_W:0]   w_diff;
    logic                 w_ge;
    logic [DIVISOR_W-1:0] n_rem;

    always_comb begin
        w_trial = {r_rem, r_quo[LEVEL_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        n_rem   = w_ge ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[LEVEL_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(LEVEL_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== hdl/padsr_voice.sv =====
// One envelope step for a single voice: phase decisions and one shared add/subtract.
// Depends on padsr_pkg (voice struct, phase codes, Q1.23 constants).
module padsr_voice
    import padsr_pkg::*;
(
    input  t_voice             i_cur,
    input  logic [CFG_W-1:0]   i_sustain,
    input  logic [LEVEL_W-1:0] i_step_a,
    input  logic [LEVEL_W-1:0] i_step_d,
    input  logic [LEVEL_W-1:0] i_step_r,
    output t_voice             o_nxt
);

    logic [LEVEL_W-1:0] w_sus;
    logic [LEVEL_W-1:0] w_step;
    logic               w_add;
    logic [LEVEL_W:0]   w_res;
    logic [LEVEL_W-1:0] w_sat;

    always_comb begin
        w_sus = sus_q23(i_sustain);
        w_add = (i_cur.phase == PH_ATTACK);
        unique case (i_cur.phase)
            PH_ATTACK: w_step = i_step_a;
            PH_DECAY:  w_step = (i_step_d == '0) ? LEVEL_W'(1) : i_step_d;
            default:   w_step = (i_step_r == '0 && w_sus != '0) ? LEVEL_W'(1) : i_step_r;
        endcase
        // one adder: invert the operand and carry in for subtraction
        w_res = {1'b0, i_cur.level}
              + (w_add ? {1'b0, w_step} : ~{1'b0, w_step})
              + {{LEVEL_W{1'b0}}, ~w_add};
        // a borrow out of the subtraction saturates at zero
        w_sat = (!w_add && w_res[LEVEL_W]) ? '0 : w_res[LEVEL_W-1:0];

        o_nxt = i_cur;
        unique case (i_cur.phase)
            PH_ATTACK: begin
                if (i_cur.level >= ONE_Q23) begin
                    o_nxt.phase = PH_DECAY;
                    o_nxt.level = ONE_Q23;
                end else begin
                    o_nxt.level = w_sat;
                end
            end
            PH_DECAY: begin
                if (i_cur.level <= w_sus) begin
                    o_nxt.phase = PH_SUSTAIN;
                    o_nxt.level = w_sus;
                end else begin
                    o_nxt.level = w_sat;
                end
            end
            PH_SUSTAIN: begin
                if (!i_cur.gate) begin
                    o_nxt.phase = PH_RELEASE;
                end else begin
                    o_nxt.level = w_sus;
                end
            end
            default: begin
                if (i_cur.level == '0) begin
                    o_nxt.active = 1'b0;
                end else begin
                    o_nxt.level = w_sat;
                end
            end
        endcase
    end

endmodule

// ===== hdl/padsr_chk.sv =====
// Port-level assertions for the polyphonic ADSR envelope core, and their bind.
// Depends on padsr_pkg (op codes, widths).
module padsr_chk
    import padsr_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic [OP_W-1:0]   i_s_tuser,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [31:0]       o_m_tdata,
    input logic [VIDX_W-1:0] o_m_tuser,
    input logic              o_m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // a tick keeps the block busy
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser == OP_TICK |=> !o_s_tready)
        else $error("ready after tick transaction");

    // note events and unused ops leave the input ready in the next cycle
    a_event_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tuser != OP_TICK |=> o_s_tready)
        else $error("note event stalled the input");

    // the last result of a tick reports the highest voice
    a_last_voice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser == VIDX_W'(VOICES - 1))
        else $error("tlast on wrong voice");

    // a held key always sounds
    a_gate_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[27] |-> o_m_tdata[26])
        else $error("gate on while voice inactive");

endmodule

bind polyphonic_adsr_envelope_core padsr_chk #(.VOICES(VOICES)) u_padsr_chk (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for polyphonic_adsr_envelope_core: directed and random MIDI
// traffic, APB knob settings and an envelope predictor. Depends on padsr_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import padsr_pkg::*;

    localparam int NVOICE         = VOICES_DEF;
    localparam int CLK_HALF       = 10;
    localparam int RST_CYCLES     = 10;
    localparam int SETTLE_CYCLES  = 100;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int RAND_PHASES    = 6;
    localparam int RAND_PER_PHASE = 20;
    localparam int unsigned FULL_SCALE = ONE_Q23;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [NOTE_W-1:0] note;
    } t_midi_msg;

    typedef struct packed {
        logic [VIDX_W-1:0]  voice;
        logic [LEVEL_W-1:0] level;
        t_phase             phase;
        logic               active;
        logic               gate;
        logic               last;
    } t_voice_report;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata  = '0;   // [6:0] note_number
    logic [OP_W-1:0]     i_s_tuser  = '0;   // [1:0] op
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [31:0]         o_m_tdata;         // [23:0] env_level, [25:24] env_phase,
                                            // [26] voice_active, [27] gate_on
    logic [VIDX_W-1:0]   o_m_tuser;         // [1:0] voice_index
    logic                o_m_tlast;         // last_voice
    logic                i_psel     = 1'b0;
    logic                i_penable  = 1'b0;
    logic                i_pwrite   = 1'b0;
    logic [3:0]          i_paddr    = '0;
    logic [31:0]         i_pwdata   = '0;
    logic [31:0]         o_prdata;
    logic                o_pready;

    polyphonic_adsr_envelope_core #(
        .VOICES (NVOICE)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // envelope predictor state
    logic [CFG_W-1:0]   knob_attack  = '0;
    logic [CFG_W-1:0]   knob_decay   = '0;
    logic [CFG_W-1:0]   knob_sustain = 12'd2048;
    logic [CFG_W-1:0]   knob_release = '0;
    logic [LEVEL_W-1:0] env_lvl   [NVOICE];
    t_phase             env_ph    [NVOICE];
    logic               voice_on  [NVOICE];
    logic               key_held  [NVOICE];
    logic [NOTE_W-1:0]  held_note [NVOICE];

    t_voice_report expected_reports[$];
    t_midi_msg     midi_pending[$];
    t_midi_msg     midi_cur;

    int  fail_cnt       = 0;
    int  msgs_accepted  = 0;
    int  reports_seen   = 0;
    int  knob_sets      = 0;
    int  cycle_cnt      = 0;
    int  tx_gap         = 0;
    int  rx_holds_asked = 0;
    int  rx_holds_done  = 0;
    bit  tx_idle_en     = 1'b1;
    bit  rx_idle_en     = 1'b1;

    initial begin
        for (int v = 0; v < NVOICE; v++) begin
            env_lvl[v]   = '0;
            env_ph[v]    = PH_ATTACK;
            voice_on[v]  = 1'b0;
            key_held[v]  = 1'b0;
            held_note[v] = '0;
        end
    end

    function automatic void envelope_step(int v);
        int unsigned s;
        int unsigned lvl;
        int unsigned step;
        s   = int'(knob_sustain) << 11;
        lvl = env_lvl[v];
        case (env_ph[v])
            PH_ATTACK: begin
                if (lvl >= FULL_SCALE) begin
                    env_ph[v] = PH_DECAY;
                    lvl = FULL_SCALE;
                end else begin
                    lvl = lvl + FULL_SCALE / (int'(knob_attack) + 1);
                end
            end
            PH_DECAY: begin
                if (lvl <= s) begin
                    env_ph[v] = PH_SUSTAIN;
                    lvl = s;
                end else begin
                    step = (FULL_SCALE - s) / (int'(knob_decay) + 1);
                    if (step == 0) step = 1;
                    lvl = (lvl > step) ? lvl - step : 0;
                end
            end
            PH_SUSTAIN: begin
                if (!key_held[v]) env_ph[v] = PH_RELEASE;
                else lvl = s;
            end
            default: begin
                if (lvl == 0) begin
                    voice_on[v] = 1'b0;
                end else begin
                    step = s / (int'(knob_release) + 1);
                    // a zero sustain gives a zero release step: the level holds
                    if (step == 0 && s != 0) step = 1;
                    lvl = (lvl > step) ? lvl - step : 0;
                end
            end
        endcase
        env_lvl[v] = LEVEL_W'(lvl);
    endfunction

    function automatic void apply_midi(t_midi_msg m);
        int held;
        t_voice_report rep;
        held = 0;
        case (m.op)
            OP_NOTE_ON: begin
                for (int v = 0; v < NVOICE; v++) if (key_held[v]) held++;
                if (held < NVOICE) begin
                    env_lvl[held]   = '0;
                    env_ph[held]    = PH_ATTACK;
                    voice_on[held]  = 1'b1;
                    key_held[held]  = 1'b1;
                    held_note[held] = m.note;
                end
            end
            OP_NOTE_OFF: begin
                for (int v = 0; v < NVOICE; v++)
                    if (held_note[v] == m.note) key_held[v] = 1'b0;
            end
            OP_TICK: begin
                for (int v = 0; v < NVOICE; v++) begin
                    envelope_step(v);
                    rep.voice  = VIDX_W'(v);
                    rep.level  = env_lvl[v];
                    rep.phase  = env_ph[v];
                    rep.active = voice_on[v];
                    rep.gate   = key_held[v];
                    rep.last   = (v == NVOICE - 1);
                    expected_reports.push_back(rep);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s expected 0x%0h actual 0x%0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // slave-side driver: predict on each accepted transaction, then load the next one
    always @(posedge i_clk) begin
        logic took;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            took = i_s_tvalid && o_s_tready;
            if (took) begin
                apply_midi(midi_cur);
                msgs_accepted++;
            end
            if (!i_s_tvalid || took) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (midi_pending.size() > 0 && tx_idle_en &&
                             $urandom_range(0, 5) == 0) begin
                    tx_gap = $urandom_range(0, 8);
                    i_s_tvalid <= 1'b0;
                end else if (midi_pending.size() > 0) begin
                    midi_cur = midi_pending.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {1'b0, midi_cur.note};
                    i_s_tuser  <= midi_cur.op;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // master-side ready: random stall bursts, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_holds_asked != rx_holds_done) begin
                rx_holds_done = rx_holds_asked;
                i_m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_voice_report want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                $error("unexpected result for voice %0d", o_m_tuser);
                fail_cnt++;
            end else begin
                want = expected_reports.pop_front();
                check_field("voice_index",  32'(want.voice),  32'(o_m_tuser));
                check_field("env_level",    32'(want.level),  32'(o_m_tdata[23:0]));
                check_field("env_phase",    32'(want.phase),  32'(o_m_tdata[25:24]));
                check_field("voice_active", 32'(want.active), 32'(o_m_tdata[26]));
                check_field("gate_on",      32'(want.gate),   32'(o_m_tdata[27]));
                check_field("last_voice",   32'(want.last),   32'(o_m_tlast));
            end
        end
    end

    task automatic send_midi(logic [OP_W-1:0] op, logic [NOTE_W-1:0] note);
        t_midi_msg m;
        m.op   = op;
        m.note = note;
        while (midi_pending.size() >= 2) @(negedge i_clk);
        midi_pending.push_back(m);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_midi(OP_TICK, '0);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (midi_pending.size() != 0 || i_s_tvalid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(t_reg r, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {r, 2'b00};
        i_pwdata  <= 32'(val);
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        case (r)
            REG_ATTACK:  knob_attack  = val;
            REG_DECAY:   knob_decay   = val;
            REG_SUSTAIN: knob_sustain = val;
            default:     knob_release = val;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_knobs(logic [CFG_W-1:0] a, logic [CFG_W-1:0] d,
                             logic [CFG_W-1:0] s, logic [CFG_W-1:0] r);
        wait_drained();
        apb_write(REG_ATTACK, a);
        apb_write(REG_DECAY, d);
        apb_write(REG_SUSTAIN, s);
        apb_write(REG_RELEASE, r);
        knob_sets++;
    endtask

    // reset knobs: idle voices tick too, slot allocation, full voice set, shared notes
    task automatic test_directed_voices();
        send_ticks(1);
        send_midi(OP_UNUSED, 7'd127);
        send_midi(OP_NOTE_ON, 7'd0);
        send_midi(OP_NOTE_ON, 7'd127);
        send_ticks(1);
        send_midi(OP_NOTE_OFF, 7'd127);
        // slot 1 is restarted while it still sounds
        send_midi(OP_NOTE_ON, 7'd85);
        send_midi(OP_NOTE_ON, 7'd42);
        send_midi(OP_NOTE_ON, 7'd0);
        // all gates held: dropped
        send_midi(OP_NOTE_ON, 7'd99);
        send_ticks(4);
        send_midi(OP_NOTE_OFF, 7'd0);
        send_midi(OP_NOTE_OFF, 7'd3);
        send_ticks(4);
        send_midi(OP_NOTE_OFF, 7'd85);
        send_midi(OP_NOTE_OFF, 7'd42);
        send_ticks(3);
    endtask

    task automatic test_knob_extremes();
        set_knobs(12'd0, 12'd0, 12'd0, 12'd0);
        send_midi(OP_NOTE_ON, 7'd5);
        send_ticks(5);
        send_midi(OP_NOTE_OFF, 7'd5);
        send_ticks(3);
        set_knobs(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        send_midi(OP_NOTE_ON, 7'd64);
        send_ticks(3);
        // attack overshoots full scale; decay step truncates below one LSB
        set_knobs(12'd2, 12'd4095, 12'd4095, 12'd0);
        send_midi(OP_NOTE_ON, 7'd67);
        send_ticks(7);
        set_knobs(12'd0, 12'd0, 12'd4095, 12'd4095);
        send_midi(OP_NOTE_OFF, 7'd64);
        send_midi(OP_NOTE_OFF, 7'd67);
        send_midi(OP_NOTE_ON, 7'd70);
        send_ticks(4);
        send_midi(OP_NOTE_OFF, 7'd70);
        send_ticks(2);
        // zero sustain mid-release: the release step is zero and the level stays
        set_knobs(12'd0, 12'd0, 12'd0, 12'd4095);
        send_ticks(3);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        rx_holds_asked++;
        send_midi(OP_NOTE_ON, 7'd60);
        send_ticks(3);
        send_midi(OP_NOTE_ON, 7'd64);
        send_ticks(3);
        send_midi(OP_NOTE_OFF, 7'd60);
        send_ticks(2);
        wait_drained();
    endtask

    task automatic test_sender_pause();
        send_ticks(3);
        wait_drained();
        send_midi(OP_NOTE_OFF, 7'd64);
        send_ticks(3);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        logic [NOTE_W-1:0] pool [6] = '{7'd0, 7'd35, 7'd60, 7'd64, 7'd67, 7'd127};
        logic [CFG_W-1:0]  k [4];
        logic [NOTE_W-1:0] note;
        int pick;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int i = 0; i < 4; i++) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)       k[i] = CFG_W'($urandom_range(0, 3));
                else if (pick < 8)  k[i] = CFG_W'($urandom_range(0, 4095));
                else if (pick == 8) k[i] = 12'd4095;
                else                k[i] = 12'd0;
            end
            if (ph == RAND_PHASES - 1) begin
                wait_drained();
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            set_knobs(k[0], k[1], k[2], k[3]);
            for (int i = 0; i < RAND_PER_PHASE; i++) begin
                note = ($urandom_range(0, 3) == 0) ? NOTE_W'($urandom_range(0, 127))
                                                   : pool[$urandom_range(0, 5)];
                pick = $urandom_range(0, 99);
                if (pick < 48)      send_midi(OP_TICK, note);
                else if (pick < 74) send_midi(OP_NOTE_ON, note);
                else if (pick < 94) send_midi(OP_NOTE_OFF, note);
                else                send_midi(OP_UNUSED, note);
            end
        end
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_voices();
        test_knob_extremes();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();
        wait_drained();
        $display("covered %0d input transactions, %0d voice reports, %0d knob settings",
                 msgs_accepted, reports_seen, knob_sets);
        $display("including a %0d-cycle output hold-off and a drained sender pause",
                 RX_HOLD_CYCLES);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
